// ===== rtl/qbr_pkg.sv =====
// Shared types and constants of the quadratic and biquadratic root solver.
`default_nettype none

package qbr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int TOL_WIDTH  = 16;
  localparam int COUNT_WIDTH = 3;

  typedef enum logic [1:0] {
    CLS_NEG,
    CLS_ZERO,
    CLS_POS
  } root_class_t;

  typedef struct packed {
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] coef_a;
    logic signed [DATA_WIDTH-1:0] coef_b;
    logic signed [DATA_WIDTH-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0]       root_count;
    logic signed [DATA_WIDTH-1:0] root_first;
    logic signed [DATA_WIDTH-1:0] root_second;
    logic signed [DATA_WIDTH-1:0] root_third;
    logic signed [DATA_WIDTH-1:0] root_fourth;
    logic                         divide_error;
  } out_t;

  typedef struct packed {
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0]        ma;
    logic                         a_neg;
    logic                         c_neg;
    logic                         a_zero;
  } front_side_t;

  typedef struct packed {
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0]        ma;
    logic                         a_neg;
    logic                         a_zero;
    logic                         dneg;
    logic                         dz;
  } disc_side_t;

  typedef struct packed {
    logic mode;
    logic a_zero;
    logic dneg;
    logic dz;
    logic sgn1;
    logic sgn2;
  } div_side_t;

  typedef struct packed {
    logic                  mode;
    logic                  a_zero;
    logic                  dneg;
    logic                  dz;
    root_class_t           c1;
    root_class_t           c2;
    logic [DATA_WIDTH-1:0] sat1;
    logic [DATA_WIDTH-1:0] sat2;
  } root_side_t;

endpackage

`default_nettype wire

// ===== rtl/qbr_sqrt_cell.sv =====
// One step of a restoring square root: consumes two radicand bits, yields one root bit.
`default_nettype none

module qbr_sqrt_cell #(
  parameter int NW = 66
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   n_in,
  input  logic [NW/2:0]   rem_in,
  input  logic [NW/2-1:0] root_in,
  output logic [NW-1:0]   n_out,
  output logic [NW/2:0]   rem_out,
  output logic [NW/2-1:0] root_out
);

  localparam int RW = NW / 2;

  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;
  logic [RW+2:0] diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem_in, n_in[NW-1 -: 2]};
    trial  = {1'b0, root_in, 2'b01};
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_out    <= {n_in[NW-3:0], 2'b00};
      rem_out  <= ge ? diff[RW:0] : rem_sh[RW:0];
      root_out <= {root_in[RW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qbr_div_cell.sv =====
// One step of a restoring divider: shifts in one dividend bit, yields one quotient bit.
`default_nettype none

module qbr_div_cell #(
  parameter int XW  = 50,
  parameter int DVW = 33
) (
  input  logic           clk,
  input  logic           en,
  input  logic [XW-1:0]  x_in,
  input  logic [DVW-1:0] rem_in,
  input  logic [DVW-1:0] dvs_in,
  output logic [XW-1:0]  x_out,
  output logic [DVW-1:0] rem_out,
  output logic [DVW-1:0] dvs_out
);

  logic [DVW:0] rem_sh;
  logic [DVW:0] diff;
  logic         ge;

  always_comb begin
    rem_sh = {rem_in, x_in[XW-1]};
    diff   = rem_sh - {1'b0, dvs_in};
    ge     = rem_sh >= {1'b0, dvs_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out   <= {x_in[XW-2:0], ge};
      rem_out <= ge ? diff[DVW-1:0] : rem_sh[DVW-1:0];
      dvs_out <= dvs_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/quadratic_biquadratic_root_solver_top.sv =====
// Top level of the pipelined quadratic and biquadratic real root solver.
//
//   channel  direction  handshake             beat
//   in       input      in_valid / in_ready   mode, coef_a, coef_b, coef_c
//   out      output     out_valid / out_ready root_count, four roots, divide_error
//   cfg      input      cfg_valid / cfg_ready zero_tolerance
//
// One coefficient set enters every cycle unless the output is held; the depth is set by the
// square root cell row on the discriminant, the divider cell row and the square root cell
// row on the two quotients. Reset clears all beat valids and sets zero_tolerance to 1.
// A held result stalls every stage at once; cfg_ready is always high.
`default_nettype none

module quadratic_biquadratic_root_solver_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  qbr_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output qbr_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qbr_pkg::TOL_WIDTH-1:0]    cfg_data
);

  localparam int W    = qbr_pkg::DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int TW   = qbr_pkg::TOL_WIDTH;
  localparam int DW   = 2 * W + 1;
  localparam int DSW  = 2 * W + 2;
  localparam int SRW  = DSW / 2;
  localparam int NMW  = W + 2;
  localparam int NUMW = W + 3;
  localparam int QW   = NMW + F;
  localparam int DVW  = W + 1;
  localparam int TNW  = QW + F;
  localparam int TRW  = TNW / 2;
  localparam int CW   = TRW + W;
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] sat_quot(input logic neg, input logic [QW-1:0] mag);
    logic [W-1:0] r;
    if (!neg) begin
      r = (mag > QW'(MAX_POS)) ? MAX_POS : mag[W-1:0];
    end else begin
      r = (mag > QW'(MIN_NEG)) ? MIN_NEG : ~mag[W-1:0] + 1'b1;
    end
    return r;
  endfunction

  function automatic qbr_pkg::root_class_t classify(input logic neg, input logic [QW-1:0] mag,
                                                    input logic [TW-1:0] tl);
    qbr_pkg::root_class_t c;
    priority if (neg) begin
      c = qbr_pkg::CLS_NEG;
    end else if (mag < QW'(tl)) begin
      c = qbr_pkg::CLS_ZERO;
    end else begin
      c = qbr_pkg::CLS_POS;
    end
    return c;
  endfunction

  function automatic logic [W-1:0] sat_root(input logic [TRW-1:0] r);
    return (CW'(r) > CW'(MAX_POS)) ? MAX_POS : W'(r);
  endfunction

  logic          adv;
  logic [TW-1:0] tol;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TW'(1);
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end

  // Front stage: magnitudes and the two products.
  logic [W-1:0]         f_ma, f_mb, f_mc;
  logic                 m_vld;
  qbr_pkg::front_side_t m_side;
  logic [2*W-1:0]       m_p, m_ac;

  always_comb begin
    f_ma = in_data.coef_a[W-1] ? ~in_data.coef_a + 1'b1 : in_data.coef_a;
    f_mb = in_data.coef_b[W-1] ? ~in_data.coef_b + 1'b1 : in_data.coef_b;
    f_mc = in_data.coef_c[W-1] ? ~in_data.coef_c + 1'b1 : in_data.coef_c;
  end

  // Discriminant stage.
  logic [DW-1:0]       d_p, d_q, d_sum, d_diff, d_val, d_reg;
  logic                d_lt;
  qbr_pkg::disc_side_t d_side_next;

  always_comb begin
    d_p    = DW'(m_p);
    d_q    = DW'({m_ac, 2'b00});
    d_sum  = d_p + d_q;
    d_diff = d_p - d_q;
    d_lt   = d_p < d_q;
    if (m_side.a_neg != m_side.c_neg) begin
      d_val = d_sum;
    end else begin
      d_val = d_lt ? '0 : d_diff;
    end
    d_side_next.mode   = m_side.mode;
    d_side_next.b      = m_side.b;
    d_side_next.ma     = m_side.ma;
    d_side_next.a_neg  = m_side.a_neg;
    d_side_next.a_zero = m_side.a_zero;
    d_side_next.dneg   = (m_side.a_neg == m_side.c_neg) && d_lt;
    d_side_next.dz     = d_val < (DW'(tol) << F);
  end

  // Square root row on the discriminant.
  logic [SRW:0]        sd_vld;
  qbr_pkg::disc_side_t sd_side [SRW+1];
  logic [DSW-1:0]      sd_n    [SRW+1];
  logic [SRW:0]        sd_rem  [SRW+1];
  logic [SRW-1:0]      sd_root [SRW+1];

  assign sd_n[0]    = DSW'(d_reg);
  assign sd_rem[0]  = '0;
  assign sd_root[0] = '0;

  for (genvar g = 0; g < SRW; g++) begin : g_sqrt_d
    qbr_sqrt_cell #(.NW(DSW)) u_cell (
      .clk     (clk),
      .en      (adv),
      .n_in    (sd_n[g]),
      .rem_in  (sd_rem[g]),
      .root_in (sd_root[g]),
      .n_out   (sd_n[g+1]),
      .rem_out (sd_rem[g+1]),
      .root_out(sd_root[g+1])
    );
  end

  // Numerator stage.
  qbr_pkg::disc_side_t n_in_side;
  logic [SRW-1:0]      n_s;
  logic signed [NUMW-1:0] n_nb, n_sx, n_num1, n_num2;
  logic [NMW-1:0]      n_mag1, n_mag2;
  qbr_pkg::div_side_t  n_side_next;
  logic [QW-1:0]       n_x1, n_x2;
  logic [DVW-1:0]      n_dvs;

  always_comb begin
    n_in_side = sd_side[SRW];
    n_s       = n_in_side.dz ? '0 : sd_root[SRW];
    n_nb      = -NUMW'(n_in_side.b);
    n_sx      = NUMW'(n_s);
    n_num1    = n_nb - n_sx;
    n_num2    = n_nb + n_sx;
    n_mag1    = n_num1[NUMW-1] ? NMW'(-n_num1) : NMW'(n_num1);
    n_mag2    = n_num2[NUMW-1] ? NMW'(-n_num2) : NMW'(n_num2);
    n_side_next.mode   = n_in_side.mode;
    n_side_next.a_zero = n_in_side.a_zero;
    n_side_next.dneg   = n_in_side.dneg;
    n_side_next.dz     = n_in_side.dz;
    n_side_next.sgn1   = n_num1[NUMW-1] != n_in_side.a_neg;
    n_side_next.sgn2   = n_num2[NUMW-1] != n_in_side.a_neg;
  end

  // Divider row, two lanes.
  logic [QW:0]        dv_vld;
  qbr_pkg::div_side_t dv_side [QW+1];
  logic [QW-1:0]      dv_x1 [QW+1];
  logic [DVW-1:0]     dv_r1 [QW+1];
  logic [DVW-1:0]     dv_d1 [QW+1];
  logic [QW-1:0]      dv_x2 [QW+1];
  logic [DVW-1:0]     dv_r2 [QW+1];
  logic [DVW-1:0]     dv_d2 [QW+1];

  assign dv_x1[0] = n_x1;
  assign dv_r1[0] = '0;
  assign dv_d1[0] = n_dvs;
  assign dv_x2[0] = n_x2;
  assign dv_r2[0] = '0;
  assign dv_d2[0] = n_dvs;

  for (genvar g = 0; g < QW; g++) begin : g_div
    qbr_div_cell #(.XW(QW), .DVW(DVW)) u_lane1 (
      .clk    (clk),
      .en     (adv),
      .x_in   (dv_x1[g]),
      .rem_in (dv_r1[g]),
      .dvs_in (dv_d1[g]),
      .x_out  (dv_x1[g+1]),
      .rem_out(dv_r1[g+1]),
      .dvs_out(dv_d1[g+1])
    );
    qbr_div_cell #(.XW(QW), .DVW(DVW)) u_lane2 (
      .clk    (clk),
      .en     (adv),
      .x_in   (dv_x2[g]),
      .rem_in (dv_r2[g]),
      .dvs_in (dv_d2[g]),
      .x_out  (dv_x2[g+1]),
      .rem_out(dv_r2[g+1]),
      .dvs_out(dv_d2[g+1])
    );
  end

  // Quotient stage: sign, class and saturated value of each quotient.
  qbr_pkg::div_side_t  t_in_side;
  logic                t_neg1, t_neg2;
  qbr_pkg::root_side_t t_side_next;
  logic [TNW-1:0]      t_n1, t_n2;

  always_comb begin
    t_in_side = dv_side[QW];
    t_neg1    = t_in_side.sgn1 && (dv_x1[QW] != '0);
    t_neg2    = t_in_side.sgn2 && (dv_x2[QW] != '0);
    t_side_next.mode   = t_in_side.mode;
    t_side_next.a_zero = t_in_side.a_zero;
    t_side_next.dneg   = t_in_side.dneg;
    t_side_next.dz     = t_in_side.dz;
    t_side_next.c1     = classify(t_neg1, dv_x1[QW], tol);
    t_side_next.c2     = t_in_side.dz ? qbr_pkg::CLS_NEG : classify(t_neg2, dv_x2[QW], tol);
    t_side_next.sat1   = sat_quot(t_neg1, dv_x1[QW]);
    t_side_next.sat2   = sat_quot(t_neg2, dv_x2[QW]);
  end

  // Square root row on the two quotients.
  logic [TRW:0]        st_vld;
  qbr_pkg::root_side_t st_side  [TRW+1];
  logic [TNW-1:0]      st_n1    [TRW+1];
  logic [TRW:0]        st_rem1  [TRW+1];
  logic [TRW-1:0]      st_root1 [TRW+1];
  logic [TNW-1:0]      st_n2    [TRW+1];
  logic [TRW:0]        st_rem2  [TRW+1];
  logic [TRW-1:0]      st_root2 [TRW+1];

  assign st_n1[0]    = t_n1;
  assign st_rem1[0]  = '0;
  assign st_root1[0] = '0;
  assign st_n2[0]    = t_n2;
  assign st_rem2[0]  = '0;
  assign st_root2[0] = '0;

  for (genvar g = 0; g < TRW; g++) begin : g_sqrt_t
    qbr_sqrt_cell #(.NW(TNW)) u_lane1 (
      .clk     (clk),
      .en      (adv),
      .n_in    (st_n1[g]),
      .rem_in  (st_rem1[g]),
      .root_in (st_root1[g]),
      .n_out   (st_n1[g+1]),
      .rem_out (st_rem1[g+1]),
      .root_out(st_root1[g+1])
    );
    qbr_sqrt_cell #(.NW(TNW)) u_lane2 (
      .clk     (clk),
      .en      (adv),
      .n_in    (st_n2[g]),
      .rem_in  (st_rem2[g]),
      .root_in (st_root2[g]),
      .n_out   (st_n2[g+1]),
      .rem_out (st_rem2[g+1]),
      .root_out(st_root2[g+1])
    );
  end

  // Result assembly.
  qbr_pkg::root_side_t o_side;
  logic [W-1:0]        o_r1, o_r2;
  logic                o_p1, o_p2, o_z;
  qbr_pkg::out_t       o_next;

  always_comb begin
    o_side = st_side[TRW];
    o_r1   = sat_root(st_root1[TRW]);
    o_r2   = sat_root(st_root2[TRW]);
    o_p1   = o_side.c1 == qbr_pkg::CLS_POS;
    o_p2   = o_side.c2 == qbr_pkg::CLS_POS;
    o_z    = (o_side.c1 == qbr_pkg::CLS_ZERO) || (o_side.c2 == qbr_pkg::CLS_ZERO);
    o_next = '0;
    priority if (o_side.a_zero) begin
      o_next.divide_error = 1'b1;
    end else if (o_side.dneg) begin
      o_next.root_count = '0;
    end else if (!o_side.mode) begin
      o_next.root_first = o_side.sat1;
      if (o_side.dz) begin
        o_next.root_count = 3'd1;
      end else begin
        o_next.root_count  = 3'd2;
        o_next.root_second = o_side.sat2;
      end
    end else if (o_p1 && o_p2) begin
      o_next.root_count  = 3'd4;
      o_next.root_first  = o_r1;
      o_next.root_second = ~o_r1 + 1'b1;
      o_next.root_third  = o_r2;
      o_next.root_fourth = ~o_r2 + 1'b1;
    end else if (o_p1) begin
      o_next.root_count  = o_z ? 3'd3 : 3'd2;
      o_next.root_first  = o_r1;
      o_next.root_second = ~o_r1 + 1'b1;
    end else if (o_p2) begin
      o_next.root_count  = o_z ? 3'd3 : 3'd2;
      o_next.root_first  = o_r2;
      o_next.root_second = ~o_r2 + 1'b1;
    end else begin
      o_next.root_count = o_z ? 3'd1 : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld     <= 1'b0;
      sd_vld    <= '0;
      dv_vld    <= '0;
      st_vld    <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      m_vld     <= in_valid;
      sd_vld    <= {sd_vld[SRW-1:0], m_vld};
      dv_vld    <= {dv_vld[QW-1:0], sd_vld[SRW]};
      st_vld    <= {st_vld[TRW-1:0], dv_vld[QW]};
      out_valid <= st_vld[TRW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_side.mode   <= in_data.mode;
      m_side.b      <= in_data.coef_b;
      m_side.ma     <= f_ma;
      m_side.a_neg  <= in_data.coef_a[W-1];
      m_side.c_neg  <= in_data.coef_c[W-1];
      m_side.a_zero <= in_data.coef_a == '0;
      m_p           <= f_mb * f_mb;
      m_ac          <= f_ma * f_mc;
      d_reg         <= d_val;
      sd_side[0]    <= d_side_next;
      for (int i = 1; i <= SRW; i++) begin
        sd_side[i] <= sd_side[i-1];
      end
      n_x1       <= {n_mag1, {F{1'b0}}};
      n_x2       <= {n_mag2, {F{1'b0}}};
      n_dvs      <= {n_in_side.ma, 1'b0};
      dv_side[0] <= n_side_next;
      for (int i = 1; i <= QW; i++) begin
        dv_side[i] <= dv_side[i-1];
      end
      t_n1       <= {dv_x1[QW], {F{1'b0}}};
      t_n2       <= {dv_x2[QW], {F{1'b0}}};
      st_side[0] <= t_side_next;
      for (int i = 1; i <= TRW; i++) begin
        st_side[i] <= st_side[i-1];
      end
      out_data <= o_next;
    end
  end

endmodule

`default_nettype wire
